>>> rtl/tea_pkg.sv
// Shared types, constants and the round mixing function of the TEA cipher block.
// Used by every module under rtl except tea_checker; depends on nothing else.
package tea_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned KEY_WORDS  = 4;
    localparam int unsigned KEY_IDX_W  = 2;
    localparam int unsigned ROUNDS_DEF = 32;
    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    // Register indexes of the configuration port.
    localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD3 = 2'd3;

    // Mode codes carried in tuser.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] tea_key_t;

    typedef struct packed {
        logic [WORD_W-1:0] right;
        logic [WORD_W-1:0] left;
    } tea_block_t;

    typedef struct packed {
        logic       mode;
        tea_block_t blk;
    } tea_item_t;

    // One TEA mix term: ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb), all modulo 2^32.
    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        logic [WORD_W-1:0] term_a;
        logic [WORD_W-1:0] term_b;
        logic [WORD_W-1:0] term_c;
        term_a = (w << 4) + ka;
        term_b = w + s;
        term_c = (w >> 5) + kb;
        return term_a ^ term_b ^ term_c;
    endfunction

endpackage

>>> rtl/tea_stage.sv
// One half-round pipeline stage of the TEA cipher: updates one word of the block.
// Depends on tea_pkg for the item type, key type and mixing function.
module tea_stage #(
    parameter logic             FIRST   = 1'b1,
    parameter logic [31:0]      SUM_ENC = 32'h0,
    parameter logic [31:0]      SUM_DEC = 32'h0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  tea_pkg::tea_item_t in_item,
    input  tea_pkg::tea_key_t  key,
    output logic               out_valid,
    output tea_pkg::tea_item_t out_item
);
    import tea_pkg::*;

    logic              upd_left;
    logic [WORD_W-1:0] src_word;
    logic [WORD_W-1:0] tgt_word;
    logic [WORD_W-1:0] key_a;
    logic [WORD_W-1:0] key_b;
    logic [WORD_W-1:0] round_sum;
    logic [WORD_W-1:0] mix_val;
    logic [WORD_W-1:0] new_word;
    logic              valid_reg;
    tea_item_t         item_reg;
    tea_item_t         item_next;

    // Encryption updates left then right; decryption runs the halves the other way round.
    assign upd_left  = FIRST ? (in_item.mode == MODE_ENCRYPT) : (in_item.mode == MODE_DECRYPT);
    assign src_word  = upd_left ? in_item.blk.right : in_item.blk.left;
    assign tgt_word  = upd_left ? in_item.blk.left  : in_item.blk.right;
    assign key_a     = upd_left ? key[0] : key[2];
    assign key_b     = upd_left ? key[1] : key[3];
    assign round_sum = (in_item.mode == MODE_DECRYPT) ? SUM_DEC : SUM_ENC;
    assign mix_val   = tea_mix(src_word, round_sum, key_a, key_b);
    assign new_word  = (in_item.mode == MODE_DECRYPT) ? (tgt_word - mix_val)
                                                      : (tgt_word + mix_val);

    // Build the next item with the one updated word.
    always_comb
    begin
        item_next = in_item;
        if (upd_left)
        begin
            item_next.blk.left = new_word;
        end
        else
        begin
            item_next.blk.right = new_word;
        end
    end

    // Valid bit register; cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register; needs no reset.
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/tea_skid.sv
// Output register with a skid entry that decouples the pipeline from the result stream.
// Depends on tea_pkg for the block type.
module tea_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tea_pkg::tea_block_t in_blk,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output tea_pkg::tea_block_t out_blk
);
    import tea_pkg::*;

    logic       out_valid_reg;
    logic       skid_valid_reg;
    tea_block_t out_blk_reg;
    tea_block_t skid_blk_reg;
    logic       take_in;
    logic       out_busy;

    assign in_ready = !skid_valid_reg;
    assign take_in  = in_valid && !skid_valid_reg;
    assign out_busy = out_valid_reg && !out_ready;

    // Control flags: output occupied, skid occupied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_ready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (take_in && out_busy)
            begin
                skid_valid_reg <= 1'b1;
            end
            if (!out_busy)
            begin
                out_valid_reg <= skid_valid_reg || take_in;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in && out_busy)
        begin
            skid_blk_reg <= in_blk;
        end
        if (!out_busy)
        begin
            out_blk_reg <= skid_valid_reg ? skid_blk_reg : in_blk;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blk   = out_blk_reg;

endmodule

>>> rtl/tea_block_cipher_top.sv
// Channel   Signals                               Contents (lowest bit first)
// s_        s_tvalid s_tready s_tdata s_tuser     tdata: word_left, word_right; tuser: mode
// m_        m_tvalid m_tready m_tdata             tdata: out_left, out_right
// cfg_      cfg_we cfg_index cfg_data             key_word0..key_word3 at index 0..3
//
// One block enters every cycle while s_tready is high; the result passes the stage registers, then the output register.
// Each round is split over two register stages, one per half-round word update.
// Reset clears the keys, the stage valid bits and the output flags; no clearing pass.
// A stall on m_ fills the skid entry and then holds the pipeline; nothing is lost or repeated.
// Top level of the TEA cipher block; depends on tea_pkg, tea_stage and tea_skid.
module tea_block_cipher_top #(
    parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // word_left, word_right
    input  logic                            s_tuser,   // mode
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // out_left, out_right
    // Key register writes.
    input  logic                            cfg_we,
    input  logic [tea_pkg::KEY_IDX_W-1:0]   cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]      cfg_data
);
    import tea_pkg::*;

    localparam int unsigned STAGES = 2 * ROUNDS;

    tea_key_t   key_reg;
    logic       pipe_en;
    logic       valid_pipe [0:STAGES];
    tea_item_t  item_pipe  [0:STAGES];
    tea_block_t res_blk;

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD0: key_reg[0] <= cfg_data;
                REG_KEY_WORD1: key_reg[1] <= cfg_data;
                REG_KEY_WORD2: key_reg[2] <= cfg_data;
                REG_KEY_WORD3: key_reg[3] <= cfg_data;
                default:       key_reg    <= key_reg;
            endcase
        end
    end

    // Pipeline entry.
    assign s_tready      = pipe_en;
    assign valid_pipe[0] = s_tvalid;
    assign item_pipe[0]  = '{mode: s_tuser, blk: '{right: s_tdata[63:32], left: s_tdata[31:0]}};

    // Half-round stages, two per round; both halves of a round share its round-sum constants.
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int unsigned RND = s / 2;
        localparam logic [63:0] ENC_PROD = 64'(DELTA) * 64'(RND + 1);
        localparam logic [63:0] DEC_PROD = 64'(DELTA) * 64'(ROUNDS - RND);

        tea_stage #(
            .FIRST   ((s % 2) == 0),
            .SUM_ENC (ENC_PROD[31:0]),
            .SUM_DEC (DEC_PROD[31:0])
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (valid_pipe[s]),
            .in_item   (item_pipe[s]),
            .key       (key_reg),
            .out_valid (valid_pipe[s+1]),
            .out_item  (item_pipe[s+1])
        );
    end

    // Output register and skid entry.
    tea_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_pipe[STAGES]),
        .in_blk    (item_pipe[STAGES].blk),
        .in_ready  (pipe_en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_blk   (res_blk)
    );

    assign m_tdata = {res_blk.right, res_blk.left};

endmodule

>>> rtl/tea_checker.sv
// Port-level checks of the TEA cipher block's result stream and back-pressure.
// Depends only on the top level's ports; bound to tea_block_cipher_top below.
module tea_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction withdrawn while stalled");

    // A stalled result keeps its data.
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Input is refused only after the output was stalled in the cycle before.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input refused without an output stall");

    // Once refused, input stays refused while the output stall lasts.
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !m_tready |=> !s_tready)
        else $error("input accepted while skid entry still full");

endmodule

bind tea_block_cipher_top tea_checker u_tea_checker (.*);
